// File: rtl/busy_ratio_window_monitor_assert.svh
// ----------------------------------------------------------------------------
// busy ratio window monitor assertion macros
// Shared property forms; they expect clk and rst in the using scope.
// ----------------------------------------------------------------------------
`ifndef BUSY_RATIO_WINDOW_MONITOR_ASSERT_SVH
`define BUSY_RATIO_WINDOW_MONITOR_ASSERT_SVH

// same-cycle implication
`define BRWM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("brwm same-cycle check failed");

// next-cycle implication
`define BRWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("brwm next-cycle check failed");

`endif

// File: rtl/brwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brwm_pkg
// Types and constants shared by the busy ratio window monitor.
// ----------------------------------------------------------------------------
package brwm_pkg;

  localparam int DUR_W    = 32;
  localparam int TS_W     = 48;
  localparam int PCT_W    = 7;
  localparam int OUT_W    = 8;
  localparam int MAXREC_W = 7;
  localparam int FUNC_W   = 2;
  localparam int CFG_W    = 32;
  localparam int PADDR_W  = 3;

  localparam logic [MAXREC_W-1:0] MAXREC_RESET = 7'd32;
  localparam logic [DUR_W-1:0]    WINDOW_RESET = 32'd2000000;
  localparam logic [DUR_W-1:0]    DUR_SAT      = 32'hFFFF_FFFF;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_IDLE  = 2'd0,
    FUNC_WAKE  = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic {
    REG_MAX_RECORDS = 1'b0,
    REG_WINDOW      = 1'b1
  } reg_idx_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic             idle;
    logic [DUR_W-1:0] dur;
  } rec_t;

endpackage

// File: rtl/busy_ratio_window_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// busy_ratio_window_monitor
// Busy share of a worker over a sliding window of interval records.
// ----------------------------------------------------------------------------
// Input stream s_*: tuser carries func (idle, wake, query), tdata the 48-bit
// microsecond timestamp. Idle and wake push one interval record; a query
// returns one 8-bit transfer on m_* holding load_percent (0..100).
// Idle / wake pass through ST_SPAN and ST_PUSH before the next item is
// taken; unused func code 3 is dropped without leaving ST_IDLE. In a query,
// one shared adder sums the stored records one per read of the record
// memory, subtracts evicted records, forms busy*100 in two adds and runs a
// 7-step restoring division. s_tready is high only between items.
// Results sit in an output register; a new item is accepted while it waits,
// and a finishing query waits for the register to drain when m_tready is low.
// Reset (rst, synchronous) empties the record queue, marks the worker busy,
// zeroes both timestamps and loads max_records = 32, window = 2000000 us.
// The record memory is not cleared; only occupied entries are read.
// APB registers: 0x0 max_records, 0x4 window_length_us.
// ----------------------------------------------------------------------------
module busy_ratio_window_monitor #(
  parameter int MAX_RECORDS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  // stream in
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [brwm_pkg::TS_W-1:0]       s_tdata,  // [47:0] now_us
  input  logic [brwm_pkg::FUNC_W-1:0]     s_tuser,  // [1:0] func
  // stream out
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [brwm_pkg::OUT_W-1:0]      m_tdata,  // [6:0] load_percent, [7] zero
  // config
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [brwm_pkg::PADDR_W-1:0]    paddr,
  input  logic [brwm_pkg::CFG_W-1:0]      pwdata,
  output logic [brwm_pkg::CFG_W-1:0]      prdata,
  output logic                            pready
);

  localparam int CNT_W = $clog2(MAX_RECORDS + 1);
  localparam int AW    = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int ACC_W = brwm_pkg::DUR_W + CNT_W;
  localparam int REM_W = ACC_W + brwm_pkg::PCT_W;
  localparam int ALU_W = (REM_W > brwm_pkg::TS_W) ? REM_W : brwm_pkg::TS_W;
  localparam int CW    = (CNT_W > brwm_pkg::MAXREC_W) ? CNT_W : brwm_pkg::MAXREC_W;
  localparam int SW    = CNT_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPAN,
    ST_PUSH,
    ST_WALK_RD,
    ST_WALK_T,
    ST_WALK_B,
    ST_EV_CHK,
    ST_EV_RD,
    ST_EV_T,
    ST_EV_B,
    ST_MUL0,
    ST_MUL1,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state;

  // configuration
  logic [brwm_pkg::MAXREC_W-1:0] max_records;
  logic [brwm_pkg::DUR_W-1:0]    window_length_us;

  // queue and worker state
  logic [AW-1:0]                 head;
  logic [CNT_W-1:0]              count;
  logic                          is_idle;
  logic [brwm_pkg::TS_W-1:0]     last_idle_start;
  logic [brwm_pkg::TS_W-1:0]     last_wake;

  // per-item working registers
  brwm_pkg::func_t               func;
  logic [brwm_pkg::TS_W-1:0]     now_us;
  logic [brwm_pkg::DUR_W-1:0]    dur;
  logic [ACC_W-1:0]              total;
  logic [ACC_W-1:0]              busy;
  logic [REM_W-1:0]              rem;
  logic [CNT_W-1:0]              walk_left;
  logic [AW-1:0]                 walk_slot;
  logic [2:0]                    div_k;
  logic [brwm_pkg::PCT_W-1:0]    quot;

  // shared unit
  logic [ALU_W-1:0]              alu_a;
  logic [ALU_W-1:0]              alu_b;
  brwm_pkg::alu_op_t             alu_op;
  logic [ALU_W-1:0]              alu_sum;
  logic                          alu_lt;

  // record memory
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  brwm_pkg::rec_t                mem_wdata;
  logic                          mem_re;
  logic [AW-1:0]                 mem_raddr;
  brwm_pkg::rec_t                rd_rec;

  logic [brwm_pkg::TS_W-1:0]     span_ref;
  logic [brwm_pkg::DUR_W-1:0]    span_val;
  logic [AW-1:0]                 h1;
  logic [AW-1:0]                 h2;
  logic [CNT_W-1:0]              c1;
  logic [CNT_W-1:0]              c2;
  logic [SW-1:0]                 slot_sum;
  logic [AW-1:0]                 push_slot;
  logic                          cfg_wr;
  logic                          evict;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s);
    return (s == AW'(MAX_RECORDS - 1)) ? '0 : s + AW'(1);
  endfunction

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    case (brwm_pkg::reg_idx_t'(paddr[2]))
      brwm_pkg::REG_MAX_RECORDS:
        prdata = brwm_pkg::CFG_W'(max_records);
      brwm_pkg::REG_WINDOW:
        prdata = window_length_us;
      default:
        prdata = '0;
    endcase
  end

  // ------------------------------------------------------------ shared unit
  always_comb begin
    case (func)
      brwm_pkg::FUNC_IDLE: span_ref = last_wake;
      brwm_pkg::FUNC_WAKE: span_ref = last_idle_start;
      default:             span_ref = is_idle ? last_idle_start : last_wake;
    endcase
  end

  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    alu_op = brwm_pkg::ALU_ADD;
    case (state)
      ST_SPAN: begin
        alu_a  = ALU_W'(now_us);
        alu_b  = ALU_W'(span_ref);
        alu_op = brwm_pkg::ALU_SUB;
      end
      ST_WALK_T: begin
        alu_a = ALU_W'(total);
        alu_b = ALU_W'(rd_rec.dur);
      end
      ST_WALK_B: begin
        alu_a = ALU_W'(busy);
        alu_b = ALU_W'(rd_rec.dur);
      end
      ST_EV_CHK: begin
        alu_a  = ALU_W'(window_length_us);
        alu_b  = ALU_W'(total);
        alu_op = brwm_pkg::ALU_SUB;
      end
      ST_EV_T: begin
        alu_a  = ALU_W'(total);
        alu_b  = ALU_W'(rd_rec.dur);
        alu_op = brwm_pkg::ALU_SUB;
      end
      ST_EV_B: begin
        alu_a  = ALU_W'(busy);
        alu_b  = ALU_W'(rd_rec.dur);
        alu_op = brwm_pkg::ALU_SUB;
      end
      // busy * 100 as busy*64 + busy*32 + busy*4
      ST_MUL0: begin
        alu_a = ALU_W'(busy) << 6;
        alu_b = ALU_W'(busy) << 5;
      end
      ST_MUL1: begin
        alu_a = ALU_W'(rem);
        alu_b = ALU_W'(busy) << 2;
      end
      ST_DIV: begin
        alu_a  = ALU_W'(rem);
        alu_b  = ALU_W'(total) << div_k;
        alu_op = brwm_pkg::ALU_SUB;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  brwm_alu #(
    .W (ALU_W)
  ) u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .op     (alu_op),
    .sum    (alu_sum),
    .a_lt_b (alu_lt)
  );

  // time going backwards gives zero, long spans saturate
  always_comb begin
    if (alu_lt) begin
      span_val = '0;
    end else if (|alu_sum[brwm_pkg::TS_W-1:brwm_pkg::DUR_W]) begin
      span_val = brwm_pkg::DUR_SAT;
    end else begin
      span_val = alu_sum[brwm_pkg::DUR_W-1:0];
    end
  end

  // ------------------------------------------------------------ push slots
  always_comb begin
    h1 = head;
    c1 = count;
    if (count == CNT_W'(MAX_RECORDS)) begin
      h1 = next_slot(head);
      c1 = count - CNT_W'(1);
    end
    slot_sum = SW'(h1) + SW'(c1);
    if (slot_sum >= SW'(MAX_RECORDS)) begin
      slot_sum = slot_sum - SW'(MAX_RECORDS);
    end
    push_slot = slot_sum[AW-1:0];
    c2 = c1 + CNT_W'(1);
    h2 = h1;
    if (CW'(c2) > CW'(max_records)) begin
      h2 = next_slot(h1);
      c2 = c2 - CNT_W'(1);
    end
  end

  assign evict = (count != '0) &&
                 (alu_lt || (CW'(count) > CW'(max_records)));

  // ---------------------------------------------------------------- memory
  assign mem_we         = (state == ST_PUSH);
  assign mem_waddr      = push_slot;
  assign mem_wdata.dur  = dur;
  assign mem_wdata.idle = (func == brwm_pkg::FUNC_WAKE);
  assign mem_re         = (state == ST_WALK_RD) || (state == ST_EV_RD);
  assign mem_raddr      = (state == ST_EV_RD) ? head : walk_slot;

  brwm_rec_mem #(
    .DEPTH (MAX_RECORDS),
    .AW    (AW)
  ) u_rec_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_rec)
  );

  assign s_tready = (state == ST_IDLE);

  // ------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      max_records      <= brwm_pkg::MAXREC_RESET;
      window_length_us <= brwm_pkg::WINDOW_RESET;
      head             <= '0;
      count            <= '0;
      is_idle          <= 1'b0;
      last_idle_start  <= '0;
      last_wake        <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (brwm_pkg::reg_idx_t'(paddr[2]))
          brwm_pkg::REG_MAX_RECORDS: max_records <= pwdata[brwm_pkg::MAXREC_W-1:0];
          brwm_pkg::REG_WINDOW:      window_length_us <= pwdata;
          default:                   max_records <= max_records;
        endcase
      end
      // in ST_DONE the output register is handled by the state itself
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            func   <= brwm_pkg::func_t'(s_tuser);
            now_us <= s_tdata;
            if (brwm_pkg::func_t'(s_tuser) != brwm_pkg::FUNC_NONE) begin
              state <= ST_SPAN;
            end
          end
        end
        ST_SPAN: begin
          dur <= span_val;
          if (func == brwm_pkg::FUNC_QUERY) begin
            // running interval opens the sums
            total     <= ACC_W'(span_val);
            busy      <= is_idle ? '0 : ACC_W'(span_val);
            walk_left <= count;
            walk_slot <= head;
            state     <= (count == '0) ? ST_EV_CHK : ST_WALK_RD;
          end else begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          head  <= h2;
          count <= c2;
          if (func == brwm_pkg::FUNC_IDLE) begin
            is_idle         <= 1'b1;
            last_idle_start <= now_us;
          end else begin
            is_idle   <= 1'b0;
            last_wake <= now_us;
          end
          state <= ST_IDLE;
        end
        ST_WALK_RD: begin
          state <= ST_WALK_T;
        end
        ST_WALK_T: begin
          total <= alu_sum[ACC_W-1:0];
          state <= ST_WALK_B;
        end
        ST_WALK_B: begin
          if (!rd_rec.idle) begin
            busy <= alu_sum[ACC_W-1:0];
          end
          walk_left <= walk_left - CNT_W'(1);
          walk_slot <= next_slot(walk_slot);
          state     <= (walk_left == CNT_W'(1)) ? ST_EV_CHK : ST_WALK_RD;
        end
        ST_EV_CHK: begin
          state <= evict ? ST_EV_RD : ST_MUL0;
        end
        ST_EV_RD: begin
          state <= ST_EV_T;
        end
        ST_EV_T: begin
          total <= alu_sum[ACC_W-1:0];
          state <= ST_EV_B;
        end
        ST_EV_B: begin
          if (!rd_rec.idle) begin
            busy <= alu_sum[ACC_W-1:0];
          end
          head  <= next_slot(head);
          count <= count - CNT_W'(1);
          state <= ST_EV_CHK;
        end
        ST_MUL0: begin
          rem   <= alu_sum[REM_W-1:0];
          state <= ST_MUL1;
        end
        ST_MUL1: begin
          rem   <= alu_sum[REM_W-1:0];
          div_k <= 3'(brwm_pkg::PCT_W - 1);
          quot  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (!alu_lt) begin
            rem         <= alu_sum[REM_W-1:0];
            quot[div_k] <= 1'b1;
          end
          if (div_k == '0) begin
            state <= ST_DONE;
          end else begin
            div_k <= div_k - 3'd1;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, (total == '0) ? brwm_pkg::PCT_W'(0) : quot};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ------------------------------------------------------------ assertions
  `include "busy_ratio_window_monitor_assert.svh"

  `BRWM_ASSERT_IMPL(a_evict_nonempty, state == ST_EV_RD, count != '0)
  `BRWM_ASSERT_NEXT(a_push_bound, state == ST_PUSH, count <= CNT_W'(MAX_RECORDS))
  `BRWM_ASSERT_IMPL(a_pct_range, m_tvalid, m_tdata[6:0] <= 7'd100)

endmodule

// File: rtl/brwm_rec_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brwm_rec_mem
// Interval record store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module brwm_rec_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  brwm_pkg::rec_t  wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output brwm_pkg::rec_t  rdata
);

  brwm_pkg::rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/brwm_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brwm_alu
// Shared add / subtract unit; also flags a < b on subtract.
// ----------------------------------------------------------------------------
module brwm_alu #(
  parameter int W = 50
) (
  input  logic              [W-1:0] a,
  input  logic              [W-1:0] b,
  input  brwm_pkg::alu_op_t         op,
  output logic              [W-1:0] sum,
  output logic                      a_lt_b
);

  logic [W-1:0] b_op;
  logic [W:0]   full;
  logic         is_sub;

  assign is_sub = (op == brwm_pkg::ALU_SUB);
  assign b_op   = is_sub ? ~b : b;
  assign full   = {1'b0, a} + {1'b0, b_op} + (W+1)'(is_sub);
  assign sum    = full[W-1:0];
  // carry out of a + ~b + 1 is set when a >= b
  assign a_lt_b = is_sub & ~full[W];

endmodule
